FILE: design/bu2x_pkg.sv
// Package for the 2x bilinear upscaler: field widths, register map and
// the item record passed from the row-store fetch stage to the emitter.
// No dependencies.
package bu2x_pkg;

    localparam int PIX_W       = 8;
    localparam int COORD_W     = 12;
    localparam int DIM_W       = 12;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int DEF_MAX_COLS = 2048;
    localparam int DEF_MAX_ROWS = 2048;
    localparam logic [DIM_W-1:0] RST_NUM_COLS = DIM_W'(512);
    localparam logic [DIM_W-1:0] RST_NUM_ROWS = DIM_W'(512);

    // register index, taken from paddr[2]
    typedef enum logic [0:0] {
        REG_NUM_COLS = 1'b0,
        REG_NUM_ROWS = 1'b1
    } reg_idx_t;

    // one source pixel with its neighbors and position, ready to expand
    typedef struct packed {
        logic [COORD_W-1:0] row2;     // 2r, masked to coordinate width
        logic [COORD_W-1:0] col2;     // 2c, masked to coordinate width
        logic               has_up;   // r > 0
        logic               has_left; // c > 0
        logic               eof;      // last source pixel of the frame
        logic [PIX_W-1:0]   cur;
        logic [PIX_W-1:0]   above;
        logic [PIX_W-1:0]   left;
        logic [PIX_W-1:0]   upleft;
    } item_t;

endpackage

FILE: design/bu2x_if.sv
// Stream interfaces of the upscaler: source pixel beats in, result beats out.
// Depends on bu2x_pkg for field widths.
interface bu2x_in_if;
    logic                        valid;
    logic                        ready;
    logic [bu2x_pkg::PIX_W-1:0]  pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface bu2x_out_if;
    logic                          valid;
    logic                          ready;
    logic [bu2x_pkg::COORD_W-1:0]  out_row;
    logic [bu2x_pkg::COORD_W-1:0]  out_col;
    logic [bu2x_pkg::PIX_W-1:0]    pixel_out;
    logic                          last_of_item;
    logic                          end_of_frame;

    modport source (output valid, output out_row, output out_col, output pixel_out,
                    output last_of_item, output end_of_frame, input ready);
    modport sink   (input valid, input out_row, input out_col, input pixel_out,
                    input last_of_item, input end_of_frame, output ready);
endinterface

FILE: design/bu2x_cfg.sv
// APB register block: num_cols and num_rows, with the clamped image size.
// Depends on bu2x_pkg.
module bu2x_cfg #(
    parameter int MAX_COLS = bu2x_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = bu2x_pkg::DEF_MAX_ROWS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bu2x_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bu2x_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bu2x_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output logic [$clog2(MAX_COLS+1)-1:0]     cols,
    output logic [$clog2(MAX_ROWS+1)-1:0]     rows
);
    import bu2x_pkg::*;

    localparam int CCNT_W = $clog2(MAX_COLS+1);
    localparam int RCNT_W = $clog2(MAX_ROWS+1);
    localparam int CCMP_W = (CCNT_W > DIM_W) ? CCNT_W : DIM_W;
    localparam int RCMP_W = (RCNT_W > DIM_W) ? RCNT_W : DIM_W;

    logic [DIM_W-1:0] num_cols_reg;
    logic [DIM_W-1:0] num_rows_reg;
    reg_idx_t         idx;
    logic             wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cols_reg <= RST_NUM_COLS;
            num_rows_reg <= RST_NUM_ROWS;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_NUM_COLS: num_cols_reg <= pwdata[DIM_W-1:0];
                REG_NUM_ROWS: num_rows_reg <= pwdata[DIM_W-1:0];
                default:      num_cols_reg <= num_cols_reg;
            endcase
        end
    end

    // readback
    always_comb
    begin
        unique case (idx)
            REG_NUM_COLS: prdata = APB_DATA_W'(num_cols_reg);
            REG_NUM_ROWS: prdata = APB_DATA_W'(num_rows_reg);
            default:      prdata = '0;
        endcase
    end

    // clamp: zero counts as one, oversize counts as the maximum
    always_comb
    begin
        if (num_cols_reg == '0)
            cols = CCNT_W'(1);
        else if (CCMP_W'(num_cols_reg) > CCMP_W'(MAX_COLS))
            cols = CCNT_W'(MAX_COLS);
        else
            cols = CCNT_W'(num_cols_reg);

        if (num_rows_reg == '0)
            rows = RCNT_W'(1);
        else if (RCMP_W'(num_rows_reg) > RCMP_W'(MAX_ROWS))
            rows = RCNT_W'(MAX_ROWS);
        else
            rows = RCNT_W'(num_rows_reg);
    end

endmodule

FILE: design/bu2x_fetch.sv
// Input stage: position counters, previous-row memory read/write-back,
// left and upper-left neighbor registers. Depends on bu2x_pkg, bu2x_in_if.
module bu2x_fetch #(
    parameter int MAX_COLS = bu2x_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = bu2x_pkg::DEF_MAX_ROWS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [$clog2(MAX_COLS+1)-1:0]  cols,
    input  logic [$clog2(MAX_ROWS+1)-1:0]  rows,
    bu2x_in_if.sink                        pix_in,
    output logic                           item_valid,
    input  logic                           item_take,
    output bu2x_pkg::item_t                item
);
    import bu2x_pkg::*;

    localparam int CCNT_W = $clog2(MAX_COLS+1);
    localparam int RCNT_W = $clog2(MAX_ROWS+1);
    localparam int CIDX_W = $clog2(MAX_COLS);
    localparam int RIDX_W = $clog2(MAX_ROWS);

    // row store: one entry per source column
    logic [PIX_W-1:0] mem [MAX_COLS];
    logic [PIX_W-1:0] rd_reg;

    logic [CIDX_W-1:0] col_reg,  col_next;
    logic [RIDX_W-1:0] row_reg,  row_next;
    logic              end_col, end_row;

    // stage 1: beat waiting on its memory read
    logic              s1_valid_reg;
    logic [PIX_W-1:0]  s1_pix_reg;
    logic [CIDX_W-1:0] s1_c_reg;
    logic [COORD_W-1:0] s1_row2_reg, s1_col2_reg;
    logic              s1_up_reg, s1_left_reg, s1_eof_reg;
    logic              s1_fwd_reg;
    logic [PIX_W-1:0]  s1_fwd_pix_reg;

    logic [PIX_W-1:0]  left_reg, upleft_reg;
    logic [PIX_W-1:0]  above;
    logic              in_fire, advance, fwd_hit;
    logic [CIDX_W:0]   c2;
    logic [RIDX_W:0]   r2;

    assign advance      = s1_valid_reg && item_take;
    assign pix_in.ready = !s1_valid_reg || advance;
    assign in_fire      = pix_in.valid && pix_in.ready;
    // write-back of stage 1 lands in the same cycle as this read
    assign fwd_hit      = in_fire && advance && (col_reg == s1_c_reg);

    assign end_col = (CCNT_W'(col_reg) + CCNT_W'(1)) >= cols;
    assign end_row = (RCNT_W'(row_reg) + RCNT_W'(1)) >= rows;
    assign c2      = {col_reg, 1'b0};
    assign r2      = {row_reg, 1'b0};

    // next source position
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_fire)
        begin
            if (end_col)
            begin
                col_next = '0;
                row_next = end_row ? '0 : row_reg + RIDX_W'(1);
            end
            else
            begin
                col_next = col_reg + CIDX_W'(1);
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            left_reg     <= '0;
            upleft_reg   <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;
            if (advance)
            begin
                left_reg   <= s1_pix_reg;
                upleft_reg <= above;
            end
        end
    end

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pix_reg     <= pix_in.pixel_in;
            s1_c_reg       <= col_reg;
            s1_row2_reg    <= COORD_W'(r2);
            s1_col2_reg    <= COORD_W'(c2);
            s1_up_reg      <= (row_reg != '0);
            s1_left_reg    <= (col_reg != '0);
            s1_eof_reg     <= end_col && end_row;
            s1_fwd_reg     <= fwd_hit;
            s1_fwd_pix_reg <= s1_pix_reg;
        end
    end

    // row store: read on accept, write back current pixel on hand-off
    always_ff @(posedge clk)
    begin
        if (in_fire)
            rd_reg <= mem[col_reg];
        if (advance)
            mem[s1_c_reg] <= s1_pix_reg;
    end

    assign above      = s1_fwd_reg ? s1_fwd_pix_reg : rd_reg;
    assign item_valid = s1_valid_reg;

    always_comb
    begin
        item.row2     = s1_row2_reg;
        item.col2     = s1_col2_reg;
        item.has_up   = s1_up_reg;
        item.has_left = s1_left_reg;
        item.eof      = s1_eof_reg;
        item.cur      = s1_pix_reg;
        item.above    = above;
        item.left     = left_reg;
        item.upleft   = upleft_reg;
    end

endmodule

FILE: design/bu2x_emit.sv
// Output stage: expands one source pixel into up to four result beats,
// one per cycle unless stalled, with coordinates and averages. Depends on bu2x_pkg, bu2x_out_if.
module bu2x_emit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_take,
    input  bu2x_pkg::item_t item,
    bu2x_out_if.source      pix_out
);
    import bu2x_pkg::*;

    // which result of the pixel is on the port
    typedef enum logic [1:0] {
        SEL_DIAG = 2'd0,
        SEL_UP   = 2'd1,
        SEL_LEFT = 2'd2,
        SEL_SELF = 2'd3
    } sel_t;

    sel_t  sel_reg, sel_next, sel_first;
    logic  busy_reg;
    item_t it_reg;
    logic  out_fire, done;

    logic [PIX_W+1:0] sum4;
    logic [PIX_W:0]   sum_up, sum_left;

    assign out_fire  = pix_out.valid && pix_out.ready;
    assign done      = out_fire && (sel_reg == SEL_SELF);
    assign item_take = !busy_reg || done;

    // first existing result of an incoming pixel
    always_comb
    begin
        if (item.has_up && item.has_left)
            sel_first = SEL_DIAG;
        else if (item.has_up)
            sel_first = SEL_UP;
        else if (item.has_left)
            sel_first = SEL_LEFT;
        else
            sel_first = SEL_SELF;
    end

    // following result
    always_comb
    begin
        unique case (sel_reg)
            SEL_DIAG: sel_next = SEL_UP;
            SEL_UP:   sel_next = it_reg.has_left ? SEL_LEFT : SEL_SELF;
            SEL_LEFT: sel_next = SEL_SELF;
            SEL_SELF: sel_next = SEL_SELF;
            default:  sel_next = SEL_SELF;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            sel_reg  <= SEL_SELF;
        end
        else if (item_take)
        begin
            busy_reg <= item_valid;
            if (item_valid)
                sel_reg <= sel_first;
        end
        else if (out_fire)
        begin
            sel_reg <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take && item_valid)
            it_reg <= item;
    end

    // rounded averages
    assign sum4 = (PIX_W+2)'(it_reg.upleft) + (PIX_W+2)'(it_reg.above)
                + (PIX_W+2)'(it_reg.left) + (PIX_W+2)'(it_reg.cur) + (PIX_W+2)'(2);
    assign sum_up   = (PIX_W+1)'(it_reg.above) + (PIX_W+1)'(it_reg.cur) + (PIX_W+1)'(1);
    assign sum_left = (PIX_W+1)'(it_reg.left) + (PIX_W+1)'(it_reg.cur) + (PIX_W+1)'(1);

    // result beat
    always_comb
    begin
        pix_out.valid        = busy_reg;
        pix_out.out_row      = (sel_reg == SEL_DIAG || sel_reg == SEL_UP)
                             ? it_reg.row2 - COORD_W'(1) : it_reg.row2;
        pix_out.out_col      = (sel_reg == SEL_DIAG || sel_reg == SEL_LEFT)
                             ? it_reg.col2 - COORD_W'(1) : it_reg.col2;
        pix_out.last_of_item = (sel_reg == SEL_SELF);
        pix_out.end_of_frame = (sel_reg == SEL_SELF) && it_reg.eof;
        case (sel_reg)
            SEL_DIAG: pix_out.pixel_out = sum4[PIX_W+1:2];
            SEL_UP:   pix_out.pixel_out = sum_up[PIX_W:1];
            SEL_LEFT: pix_out.pixel_out = sum_left[PIX_W:1];
            default:  pix_out.pixel_out = it_reg.cur;
        endcase
    end

endmodule

FILE: design/bilinear_upscale_2x.sv
// Top level of the streaming 2x bilinear upscaler.
// Depends on bu2x_pkg, bu2x_if, bu2x_cfg, bu2x_fetch, bu2x_emit.
//
//  channel   dir  handshake          payload
//  pix_in    in   valid/ready        pixel_in
//  pix_out   out  valid/ready        out_row, out_col, pixel_out, last_of_item, end_of_frame
//  apb       in   psel/penable       paddr, pwdata -> prdata (pready tied high)
//
// A source pixel yields 1, 2 or 4 result beats, one per cycle unless the output
// stalls, so the single result port paces the input on interior pixels.
// An input beat is registered with its row-store read, then in the emitter, before its first result.
// rst_n clears counters, neighbor registers and stage flags; the row store
// needs no clear. Output stalls hold the emitter and back up into the input.
module bilinear_upscale_2x #(
    parameter int MAX_COLS = bu2x_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = bu2x_pkg::DEF_MAX_ROWS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bu2x_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bu2x_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bu2x_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    bu2x_in_if.sink                           pix_in,
    bu2x_out_if.source                        pix_out
);
    import bu2x_pkg::*;

    logic [$clog2(MAX_COLS+1)-1:0] cols;
    logic [$clog2(MAX_ROWS+1)-1:0] rows;
    logic                          item_valid;
    logic                          item_take;
    item_t                         item;

    bu2x_cfg #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cols    (cols),
        .rows    (rows)
    );

    bu2x_fetch #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_fetch (
        .clk        (clk),
        .rst_n      (rst_n),
        .cols       (cols),
        .rows       (rows),
        .pix_in     (pix_in),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item)
    );

    bu2x_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item),
        .pix_out    (pix_out)
    );

endmodule
